/* rtl/spq_pkg.sv */
// Package: shared operation codes, status codes and the cell command bundle.
`timescale 1ns / 1ps

package spq_pkg;

	// operation codes carried by the opcode field
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic enq;   // insert the new entry in sorted place
		logic deq;   // shift every entry one cell toward the head
	} spq_cmd_t;

endpackage

/* rtl/spq_cell.sv */
// One storage cell of the sorted chain: holds one entry and trades with its neighbors.
`timescale 1ns / 1ps

module spq_cell #(
	parameter int PRIORITY_BITS = 8,
	parameter int CNT_W         = 5,
	parameter int CELL_IDX      = 0
) (
	input  logic                     clk,
	input  spq_pkg::spq_cmd_t        cmd,
	input  logic [CNT_W-1:0]         count,
	input  logic [7:0]               new_byte,
	input  logic [PRIORITY_BITS-1:0] new_prio,
	input  logic                     prev_keep,
	input  logic [7:0]               prev_byte,
	input  logic [PRIORITY_BITS-1:0] prev_prio,
	input  logic [7:0]               next_byte,
	input  logic [PRIORITY_BITS-1:0] next_prio,
	output logic [7:0]               byte_val,
	output logic [PRIORITY_BITS-1:0] prio_val,
	output logic                     keep
);

	logic [7:0]               byte_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	logic                     occupied;

	// entry stays put on enqueue when it sorts at or before the new one (FIFO on ties)
	assign occupied = count > CNT_W'(CELL_IDX);
	assign keep     = occupied && (prio_q <= new_prio);

	// payload update: insert, shift down on insert, or shift up on dequeue
	always_ff @(posedge clk) begin
		if (cmd.enq && !keep) begin
			if (prev_keep) begin
				byte_q <= new_byte;
				prio_q <= new_prio;
			end else begin
				byte_q <= prev_byte;
				prio_q <= prev_prio;
			end
		end else if (cmd.deq) begin
			byte_q <= next_byte;
			prio_q <= next_prio;
		end
	end

	assign byte_val = byte_q;
	assign prio_val = prio_q;

endmodule

/* rtl/sorted_priority_queue_top.sv */
// Top level: sorted shift-register priority queue with registered result beat.
`timescale 1ns / 1ps

// Minimum-priority queue of QUEUE_DEPTH entries kept sorted in a chain of cells,
// lowest priority number at the head and first-in-first-out among equal priorities.
// Every cell compares its priority with the incoming one in parallel, so one
// operation beat (enqueue or dequeue) can be taken every cycle when not stalled;
// the result beat appears on the output register in the cycle after acceptance.
// The input stalls only while a result beat waits on a stalled output. A dequeue
// of an empty queue returns underflow; an enqueue into a full queue is refused
// with overflow. fill_count carries the low 5 bits of the count.
module sorted_priority_queue_top #(
	parameter int QUEUE_DEPTH   = 16,
	parameter int PRIORITY_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       opcode,
	input  logic [7:0] item_byte,
	input  logic [7:0] item_priority,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [7:0] popped_byte,
	output logic       popped_valid,
	output logic [4:0] fill_count
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0]         count_q;
	logic                     out_valid_q;
	logic [1:0]               status_q;
	logic [7:0]               popped_byte_q;
	logic                     popped_valid_q;
	logic [CNT_W-1:0]         fill_q;

	logic                     accept;
	logic                     full;
	logic                     empty;
	logic [PRIORITY_BITS-1:0] new_prio;
	spq_pkg::spq_cmd_t        cmd;

	logic [7:0]               cell_byte [QUEUE_DEPTH];
	logic [PRIORITY_BITS-1:0] cell_prio [QUEUE_DEPTH];
	logic                     cell_keep [QUEUE_DEPTH];

	// input handshake: blocked only by a waiting result beat
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign full     = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign new_prio = PRIORITY_BITS'(item_priority);

	// command decode, refused operations leave the chain untouched
	assign cmd.enq = accept && (opcode == spq_pkg::OP_ENQUEUE) && !full;
	assign cmd.deq = accept && (opcode == spq_pkg::OP_DEQUEUE) && !empty;

	// chain of cells
	for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
		logic                     prev_keep;
		logic [7:0]               prev_byte;
		logic [PRIORITY_BITS-1:0] prev_prio;
		logic [7:0]               next_byte;
		logic [PRIORITY_BITS-1:0] next_prio;

		if (gi == 0) begin : g_head
			// the head takes the new entry whenever it does not keep its own
			assign prev_keep = 1'b1;
			assign prev_byte = item_byte;
			assign prev_prio = new_prio;
		end else begin : g_body
			assign prev_keep = cell_keep[gi-1];
			assign prev_byte = cell_byte[gi-1];
			assign prev_prio = cell_prio[gi-1];
		end

		if (gi == QUEUE_DEPTH - 1) begin : g_tail
			assign next_byte = '0;
			assign next_prio = '0;
		end else begin : g_inner
			assign next_byte = cell_byte[gi+1];
			assign next_prio = cell_prio[gi+1];
		end

		spq_cell #(
			.PRIORITY_BITS(PRIORITY_BITS),
			.CNT_W        (CNT_W),
			.CELL_IDX     (gi)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.count    (count_q),
			.new_byte (item_byte),
			.new_prio (new_prio),
			.prev_keep(prev_keep),
			.prev_byte(prev_byte),
			.prev_prio(prev_prio),
			.next_byte(next_byte),
			.next_prio(next_prio),
			.byte_val (cell_byte[gi]),
			.prio_val (cell_prio[gi]),
			.keep     (cell_keep[gi])
		);
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.enq) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.deq) begin
			count_q <= count_q - 1'b1;
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (accept) begin
			if (opcode == spq_pkg::OP_ENQUEUE) begin
				status_q       <= full ? spq_pkg::ST_OVERFLOW : spq_pkg::ST_OK;
				popped_byte_q  <= '0;
				popped_valid_q <= 1'b0;
				fill_q         <= full ? count_q : count_q + 1'b1;
			end else begin
				status_q       <= empty ? spq_pkg::ST_UNDERFLOW : spq_pkg::ST_OK;
				popped_byte_q  <= empty ? 8'd0 : cell_byte[0];
				popped_valid_q <= !empty;
				fill_q         <= empty ? count_q : count_q - 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign popped_byte  = popped_byte_q;
	assign popped_valid = popped_valid_q;
	assign fill_count   = 5'(fill_q);

endmodule

/* rtl/spq_checker.sv */
// Checker on the top-level ports of the priority queue, with its bind.
`timescale 1ns / 1ps

module spq_checker #(
	parameter int QUEUE_DEPTH = 16
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] status,
	input logic [7:0] popped_byte,
	input logic       popped_valid,
	input logic [4:0] fill_count
);

	// a waiting result beat blocks new operations
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input accepted while result beat stalled");

	// underflow only ever reported on an empty queue
	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == spq_pkg::ST_UNDERFLOW |-> fill_count == 5'd0)
		else $error("underflow reported with entries held");

	// overflow only ever reported on a full queue
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == spq_pkg::ST_OVERFLOW |-> fill_count == 5'(QUEUE_DEPTH))
		else $error("overflow reported below full");

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(popped_byte)
			&& $stable(popped_valid) && $stable(fill_count))
		else $error("stalled result beat changed");

	// an idle input leaves no result behind
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && !in_stall) && !(out_valid && out_stall) |=> !out_valid)
		else $error("result beat without an operation");

endmodule

bind sorted_priority_queue_top spq_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_spq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.popped_byte (popped_byte),
	.popped_valid(popped_valid),
	.fill_count  (fill_count)
);

/* bench/sorted_priority_queue_top_test.sv */
// Testbench for the sorted minimum-priority queue: random and directed beats vs. a predictor.
`timescale 1ns / 1ps

module sorted_priority_queue_top_test;

	localparam int DEPTH       = 16;
	localparam int PRIO_BITS   = 8;
	localparam int HOLD_CYCLES = 80;
	localparam int SETTLE      = 8;
	localparam int MAX_REPORTS = 10;

	// one operation beat and one result beat
	typedef struct packed {
		logic       opcode;
		logic [7:0] item_byte;
		logic [7:0] item_priority;
	} pq_op_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] popped_byte;
		logic       popped_valid;
		logic [4:0] fill_count;
	} pq_result_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       in_valid      = 1'b0;
	logic       in_stall;
	logic       opcode        = spq_pkg::OP_ENQUEUE;
	logic [7:0] item_byte     = 8'd0;
	logic [7:0] item_priority = 8'd0;
	logic       out_valid;
	logic       out_stall     = 1'b0;
	logic [1:0] status;
	logic [7:0] popped_byte;
	logic       popped_valid;
	logic [4:0] fill_count;

	pq_op_t     pending_ops[$];
	pq_result_t expected_results[$];

	// shadow copy of the sorted store
	logic [7:0]           shadow_byte [DEPTH];
	logic [PRIO_BITS-1:0] shadow_prio [DEPTH];
	int                   shadow_count = 0;

	int beats_sent     = 0;
	int beats_taken    = 0;
	int mismatch_count = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct  = 0;
	bit pressure_on     = 1'b0;
	int hold_cnt        = 0;
	pq_op_t next_op;

	sorted_priority_queue_top #(
		.QUEUE_DEPTH   (DEPTH),
		.PRIORITY_BITS (PRIO_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.item_byte     (item_byte),
		.item_priority (item_priority),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.popped_byte   (popped_byte),
		.popped_valid  (popped_valid),
		.fill_count    (fill_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// apply one operation to the shadow store and return the result it yields
	function automatic pq_result_t queue_apply(input logic op, input logic [7:0] b,
			input logic [7:0] p);
		pq_result_t res;
		int pos;
		res = '0;
		if (op == spq_pkg::OP_ENQUEUE) begin
			if (shadow_count >= DEPTH) begin
				res.status = spq_pkg::ST_OVERFLOW;
			end else begin
				// new entry goes behind every entry of equal or lower number
				pos = 0;
				while (pos < shadow_count && shadow_prio[pos] <= p[PRIO_BITS-1:0])
					pos++;
				for (int i = shadow_count; i > pos; i--) begin
					shadow_byte[i] = shadow_byte[i-1];
					shadow_prio[i] = shadow_prio[i-1];
				end
				shadow_byte[pos] = b;
				shadow_prio[pos] = p[PRIO_BITS-1:0];
				shadow_count++;
				res.status = spq_pkg::ST_OK;
			end
		end else if (shadow_count == 0) begin
			res.status = spq_pkg::ST_UNDERFLOW;
		end else begin
			res.status       = spq_pkg::ST_OK;
			res.popped_byte  = shadow_byte[0];
			res.popped_valid = 1'b1;
			for (int i = 1; i < shadow_count; i++) begin
				shadow_byte[i-1] = shadow_byte[i];
				shadow_prio[i-1] = shadow_prio[i];
			end
			shadow_count--;
		end
		res.fill_count = shadow_count[4:0];
		return res;
	endfunction

	function automatic void note_mismatch(input string what, input pq_result_t want,
			input pq_result_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display({"%0t: %s: expected st=%0d byte=%02h pv=%0b fill=%0d,",
				" got st=%0d byte=%02h pv=%0b fill=%0d"},
				$realtime, what, want.status, want.popped_byte, want.popped_valid,
				want.fill_count, got.status, got.popped_byte, got.popped_valid,
				got.fill_count);
	endfunction

	// sender: new beat once the previous one has been taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || beats_taken == beats_sent)) begin
			if (pending_ops.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				next_op = pending_ops.pop_front();
				in_valid      <= 1'b1;
				opcode        <= next_op.opcode;
				item_byte     <= next_op.item_byte;
				item_priority <= next_op.item_priority;
				beats_sent++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with a long hold-off while the pressure phase runs
	always @(negedge clk) begin
		if (pressure_on && hold_cnt < HOLD_CYCLES) begin
			out_stall <= 1'b1;
			hold_cnt  <= hold_cnt + 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
			if (!pressure_on)
				hold_cnt <= 0;
		end
	end

	// accepted input beat: predict its result
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			expected_results.push_back(queue_apply(opcode, item_byte, item_priority));
			beats_taken++;
		end
	end

	// accepted result beat: compare with the oldest prediction
	always @(posedge clk) begin
		pq_result_t got;
		got = '{status, popped_byte, popped_valid, fill_count};
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0)
				note_mismatch("unexpected result", '0, got);
			else if (expected_results[0] !== got)
				note_mismatch("result mismatch", expected_results.pop_front(), got);
			else
				void'(expected_results.pop_front());
		end
	end

	task automatic push_op(input logic op, input logic [7:0] b, input logic [7:0] p);
		pending_ops.push_back('{op, b, p});
	endtask

	// random bursts: enqueue-heavy, dequeue-heavy or mixed, sometimes with many ties
	task automatic queue_bursts(input int total);
		int left;
		int burst_len;
		int enq_pct;
		bit tie_heavy;
		logic [7:0] p;
		left = total;
		while (left > 0) begin
			burst_len = $urandom_range(4, 40);
			case ($urandom_range(2))
				0: enq_pct = 80;
				1: enq_pct = 20;
				default: enq_pct = 50;
			endcase
			tie_heavy = ($urandom_range(3) == 0);
			for (int i = 0; i < burst_len && left > 0; i++) begin
				if (tie_heavy)
					p = 8'($urandom_range(3));
				else if ($urandom_range(15) == 0)
					p = $urandom_range(1) ? 8'hFF : 8'h00;
				else
					p = 8'($urandom_range(255));
				push_op(($urandom_range(99) < enq_pct) ? spq_pkg::OP_ENQUEUE
					: spq_pkg::OP_DEQUEUE, 8'($urandom_range(255)), p);
				left--;
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_ops.size() != 0 || beats_sent != beats_taken ||
				expected_results.size() != 0)
			@(posedge clk);
	endtask

	// hard limit on the run
	initial begin
		#5ms;
		$display("sorted_priority_queue_top_test failed");
		$finish;
	end

	// sequence of phases
	initial begin
		logic [7:0] fill_prio [10];
		fill_prio = '{8'h80, 8'h01, 8'hFE, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'h80, 8'h40, 8'h00};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty dequeue, extremes, ties, fill to full, overflow, partial drain
		push_op(spq_pkg::OP_DEQUEUE, 8'hFF, 8'hFF);
		push_op(spq_pkg::OP_ENQUEUE, 8'h00, 8'h80);
		push_op(spq_pkg::OP_ENQUEUE, 8'hFF, 8'h00);
		push_op(spq_pkg::OP_ENQUEUE, 8'h11, 8'hFF);
		push_op(spq_pkg::OP_ENQUEUE, 8'h22, 8'h80);
		push_op(spq_pkg::OP_ENQUEUE, 8'h33, 8'h00);
		push_op(spq_pkg::OP_ENQUEUE, 8'h44, 8'hFF);
		for (int i = 0; i < 10; i++)
			push_op(spq_pkg::OP_ENQUEUE, 8'(8'h50 + i), fill_prio[i]);
		push_op(spq_pkg::OP_ENQUEUE, 8'hAA, 8'h00);
		repeat (6) push_op(spq_pkg::OP_DEQUEUE, 8'h00, 8'h00);
		wait_drained();

		// no idling
		queue_bursts(360);
		wait_drained();

		// sender idles
		sender_idle_pct = 58;
		queue_bursts(360);
		wait_drained();

		// receiver stalls
		sender_idle_pct = 0;
		recv_stall_pct  = 58;
		queue_bursts(360);
		wait_drained();

		// both idle
		sender_idle_pct = 21;
		recv_stall_pct  = 21;
		queue_bursts(360);
		wait_drained();

		// long receiver hold-off while the sender keeps offering
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		pressure_on     = 1'b1;
		queue_bursts(80);
		wait_drained();
		pressure_on = 1'b0;

		repeat (SETTLE) @(posedge clk);
		if (expected_results.size() != 0)
			note_mismatch("missing result", expected_results[0], '0);

		if (mismatch_count == 0) begin
			$display("sorted_priority_queue_top_test passed");
		end else begin
			$display("sorted_priority_queue_top_test failed");
		end
		$finish;
	end

endmodule
